[rtl/core/qau_pkg.sv]
// Shared types and constants for the quaternion arithmetic unit.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none

package qau_pkg;

    localparam int DEF_WIDTH     = 16;
    localparam int DEF_FRAC_BITS = 8;

    typedef enum logic [1:0] {
        FUNC_ADD   = 2'd0,
        FUNC_SUB   = 2'd1,
        FUNC_HAM   = 2'd2,
        FUNC_SCALE = 2'd3
    } func_t;

    // Hamilton product: component c takes term t as a[t] * b[c ^ t].
    // A set bit [c][t] means that term is subtracted.
    localparam logic [3:0][3:0] HAM_NEG = {4'b0100, 4'b0010, 4'b1000, 4'b1110};

endpackage

`default_nettype wire

[rtl/core/qau_in_if.sv]
// Operand channel of the quaternion arithmetic unit: valid/ready plus payload.
// Depends on qau_pkg for the default component width.
`default_nettype none

interface qau_in_if
    import qau_pkg::*;
#(
    parameter int WIDTH = DEF_WIDTH
);
    logic                    valid;
    logic                    ready;
    logic [1:0]              func;
    logic signed [WIDTH-1:0] a_real;
    logic signed [WIDTH-1:0] a_i;
    logic signed [WIDTH-1:0] a_j;
    logic signed [WIDTH-1:0] a_k;
    logic signed [WIDTH-1:0] b_real;
    logic signed [WIDTH-1:0] b_i;
    logic signed [WIDTH-1:0] b_j;
    logic signed [WIDTH-1:0] b_k;
    logic signed [WIDTH-1:0] scale;

    modport source (
        output valid, func, a_real, a_i, a_j, a_k, b_real, b_i, b_j, b_k, scale,
        input  ready
    );

    modport sink (
        input  valid, func, a_real, a_i, a_j, a_k, b_real, b_i, b_j, b_k, scale,
        output ready
    );
endinterface

`default_nettype wire

[rtl/core/qau_out_if.sv]
// Result channel of the quaternion arithmetic unit: valid/ready plus payload.
// Depends on qau_pkg for the default component width.
`default_nettype none

interface qau_out_if
    import qau_pkg::*;
#(
    parameter int WIDTH = DEF_WIDTH
);
    logic                    valid;
    logic                    ready;
    logic signed [WIDTH-1:0] r_real;
    logic signed [WIDTH-1:0] r_i;
    logic signed [WIDTH-1:0] r_j;
    logic signed [WIDTH-1:0] r_k;
    logic                    overflow;

    modport source (
        output valid, r_real, r_i, r_j, r_k, overflow,
        input  ready
    );

    modport sink (
        input  valid, r_real, r_i, r_j, r_k, overflow,
        output ready
    );
endinterface

`default_nettype wire

[rtl/core/qau_sat.sv]
// Final scaling of one result component: optional right shift by the fraction
// width, then saturation to the signed component range. Uses qau_pkg defaults.
`default_nettype none

module qau_sat
    import qau_pkg::*;
#(
    parameter int WIDTH     = DEF_WIDTH,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  wire logic signed [2*WIDTH+1:0] acc,
    input  wire logic                      shift_en,
    output logic signed [WIDTH-1:0]        res,
    output logic                           ovf
);
    localparam int AW = 2 * WIDTH + 2;

    logic signed [AW-1:0] shifted;
    logic [AW-WIDTH:0]    upper;
    logic                 fits;

    // The rounding constant is already in acc, so the shift truncates.
    assign shifted = shift_en ? (acc >>> FRAC_BITS) : acc;
    assign upper   = shifted[AW-1:WIDTH-1];
    assign fits    = (&upper) | ~(|upper);
    assign ovf     = ~fits;
    assign res     = fits ? shifted[WIDTH-1:0]
                          : {shifted[AW-1], {(WIDTH-1){~shifted[AW-1]}}};
endmodule

`default_nettype wire

[rtl/core/quaternion_arithmetic_unit.sv]
// Quaternion arithmetic unit: add, subtract, Hamilton product, scalar times b.
// An operand transfer is registered in stage 1, then stage 2, then stage 3, whose output is the result.
// Throughput: one item per cycle unless result.ready stalls it; each of the three
// stages has its own valid bit and accepts whenever it is empty or its successor is moving.
// Reset clears only the stage valid bits; datapath registers are not reset.
// Depends on qau_pkg, qau_in_if, qau_out_if and qau_sat.
`default_nettype none

module quaternion_arithmetic_unit
    import qau_pkg::*;
#(
    parameter int WIDTH     = DEF_WIDTH,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  wire logic clk,
    input  wire logic rst_n,
    qau_in_if.sink    operand,
    qau_out_if.source result
);
    localparam int PW = 2 * WIDTH;
    localparam int AW = 2 * WIDTH + 2;
    localparam logic [AW-1:0] ROUND = (AW'(1) << FRAC_BITS) >> 1;
    localparam logic signed [WIDTH-1:0] MAXV = {1'b0, {(WIDTH-1){1'b1}}};
    localparam logic signed [WIDTH-1:0] MINV = {1'b1, {(WIDTH-1){1'b0}}};

    // Stage 1: products and componentwise sums.
    logic                    v1_reg;
    func_t                   func1_reg;
    logic signed [PW-1:0]    prod1_reg [4][4];
    logic signed [PW-1:0]    prod1_next [4][4];
    logic signed [WIDTH:0]   sum1_reg [4];
    logic signed [WIDTH:0]   sum1_next [4];

    // Stage 2: accumulated component values, rounding constant included.
    logic                    v2_reg;
    logic                    mul2_reg;
    logic signed [AW-1:0]    acc2_reg [4];
    logic signed [AW-1:0]    acc2_next [4];

    // Stage 3: output register.
    logic                    v3_reg;
    logic signed [WIDTH-1:0] r_reg [4];
    logic signed [WIDTH-1:0] r_next [4];
    logic                    ovf_reg;
    logic [3:0]              ovf_vec;

    logic rdy1;
    logic rdy2;
    logic rdy3;

    logic signed [WIDTH-1:0] a_vec [4];
    logic signed [WIDTH-1:0] b_vec [4];
    func_t                   func_in;

    assign rdy3 = ~v3_reg | result.ready;
    assign rdy2 = ~v2_reg | rdy3;
    assign rdy1 = ~v1_reg | rdy2;
    assign operand.ready = rdy1;

    assign func_in  = func_t'(operand.func);
    assign a_vec[0] = operand.a_real;
    assign a_vec[1] = operand.a_i;
    assign a_vec[2] = operand.a_j;
    assign a_vec[3] = operand.a_k;
    assign b_vec[0] = operand.b_real;
    assign b_vec[1] = operand.b_i;
    assign b_vec[2] = operand.b_j;
    assign b_vec[3] = operand.b_k;

    // For scaling, the scalar replaces a_real, so term 0 of component c is
    // scale * b[c], the only product that operation needs.
    always_comb
    begin
        logic signed [WIDTH-1:0] x;
        for (int c = 0; c < 4; c++)
        begin
            for (int t = 0; t < 4; t++)
            begin
                x = (t == 0 && func_in == FUNC_SCALE) ? operand.scale : a_vec[t];
                prod1_next[c][t] = x * b_vec[2'(c) ^ 2'(t)];
            end
            if (func_in == FUNC_SUB)
            begin
                sum1_next[c] = {a_vec[c][WIDTH-1], a_vec[c]} - {b_vec[c][WIDTH-1], b_vec[c]};
            end
            else
            begin
                sum1_next[c] = {a_vec[c][WIDTH-1], a_vec[c]} + {b_vec[c][WIDTH-1], b_vec[c]};
            end
        end
    end

    always_comb
    begin
        logic signed [AW-1:0] term;
        term = '0;
        for (int c = 0; c < 4; c++)
        begin
            case (func1_reg)
                FUNC_HAM:
                begin
                    acc2_next[c] = ROUND;
                    for (int t = 0; t < 4; t++)
                    begin
                        term = {{(AW-PW){prod1_reg[c][t][PW-1]}}, prod1_reg[c][t]};
                        if (HAM_NEG[c][t])
                        begin
                            acc2_next[c] = acc2_next[c] - term;
                        end
                        else
                        begin
                            acc2_next[c] = acc2_next[c] + term;
                        end
                    end
                end
                FUNC_SCALE:
                begin
                    term = {{(AW-PW){prod1_reg[c][0][PW-1]}}, prod1_reg[c][0]};
                    acc2_next[c] = term + ROUND;
                end
                default:
                begin
                    acc2_next[c] = {{(AW-WIDTH-1){sum1_reg[c][WIDTH]}}, sum1_reg[c]};
                end
            endcase
        end
    end

    for (genvar g = 0; g < 4; g++)
    begin : g_sat
        qau_sat #(
            .WIDTH     (WIDTH),
            .FRAC_BITS (FRAC_BITS)
        ) u_sat (
            .acc      (acc2_reg[g]),
            .shift_en (mul2_reg),
            .res      (r_next[g]),
            .ovf      (ovf_vec[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= operand.valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            func1_reg <= func_in;
            prod1_reg <= prod1_next;
            sum1_reg  <= sum1_next;
        end
        if (rdy2)
        begin
            mul2_reg <= (func1_reg == FUNC_HAM) || (func1_reg == FUNC_SCALE);
            acc2_reg <= acc2_next;
        end
        if (rdy3)
        begin
            r_reg   <= r_next;
            ovf_reg <= |ovf_vec;
        end
    end

    assign result.valid    = v3_reg;
    assign result.r_real   = r_reg[0];
    assign result.r_i      = r_reg[1];
    assign result.r_j      = r_reg[2];
    assign result.r_k      = r_reg[3];
    assign result.overflow = ovf_reg;

    // The operand side only stalls when every stage holds an item.
    a_full_before_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !operand.ready |-> (v1_reg && v2_reg && v3_reg))
        else $error("operand side stalled with an empty pipeline stage");

    // A stalled stage 2 keeps its contents.
    a_stage2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && !rdy3) |=> (v2_reg && $stable(mul2_reg) && $stable(acc2_reg[0])))
        else $error("stage 2 changed while stalled");

    // A sum or difference always fits one bit above the component width.
    a_addsub_narrow: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && !mul2_reg) |->
            ((&acc2_reg[1][AW-1:WIDTH]) || !(|acc2_reg[1][AW-1:WIDTH])))
        else $error("add/sub accumulator exceeds its expected range");

    // Overflow means at least one component sits at a range limit.
    a_ovf_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && ovf_reg) |->
            (r_reg[0] == MAXV || r_reg[0] == MINV || r_reg[1] == MAXV || r_reg[1] == MINV ||
             r_reg[2] == MAXV || r_reg[2] == MINV || r_reg[3] == MAXV || r_reg[3] == MINV))
        else $error("overflow flagged without a saturated component");
endmodule

`default_nettype wire

[verif/quaternion_arithmetic_unit_tb.sv]
`timescale 1ns / 100ps
// Testbench for quaternion_arithmetic_unit: directed and random operand streams
// checked against an in-bench model of add, subtract, Hamilton product and scaling.
// Depends on qau_pkg, qau_in_if, qau_out_if and the unit itself.

module quaternion_arithmetic_unit_tb
    import qau_pkg::*;
;
    localparam int W = DEF_WIDTH;
    localparam int F = DEF_FRAC_BITS;
    localparam int ITEMS_PER_PHASE = 350;
    localparam int SETTLE_CYCLES = 8;
    localparam int unsigned SENDER_IDLE [4] = '{0, 69, 0, 23};
    localparam int unsigned RECEIVER_STALL [4] = '{0, 0, 69, 23};

    localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] ONE  = W'(1 << F);
    localparam logic signed [W-1:0] HALF = W'(1 << (F - 1));
    localparam logic signed [W-1:0] EDGE_VALUES [8] = '{MAXV, MINV, 0, -1, 1, ONE, -ONE, HALF};

    typedef struct packed {
        func_t                func;
        logic signed [W-1:0]  a_real;
        logic signed [W-1:0]  a_i;
        logic signed [W-1:0]  a_j;
        logic signed [W-1:0]  a_k;
        logic signed [W-1:0]  b_real;
        logic signed [W-1:0]  b_i;
        logic signed [W-1:0]  b_j;
        logic signed [W-1:0]  b_k;
        logic signed [W-1:0]  scale;
    } operand_t;

    typedef struct packed {
        logic signed [W-1:0]  r_real;
        logic signed [W-1:0]  r_i;
        logic signed [W-1:0]  r_j;
        logic signed [W-1:0]  r_k;
        logic                 overflow;
    } quat_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    operand_t     drive_op = '0;
    logic         drive_valid = 1'b0;
    logic         take_ready = 1'b0;

    int unsigned  sender_idle_pct = 0;
    int unsigned  receiver_stall_pct = 0;
    int unsigned  mismatches = 0;

    operand_t     operand_backlog [$];
    quat_result_t predicted_results [$];

    qau_in_if  #(.WIDTH(W)) operand_bus ();
    qau_out_if #(.WIDTH(W)) result_bus ();

    assign {operand_bus.func, operand_bus.a_real, operand_bus.a_i, operand_bus.a_j,
            operand_bus.a_k, operand_bus.b_real, operand_bus.b_i, operand_bus.b_j,
            operand_bus.b_k, operand_bus.scale} = drive_op;
    assign operand_bus.valid = drive_valid;
    assign result_bus.ready  = take_ready;

    quaternion_arithmetic_unit #(
        .WIDTH(W),
        .FRAC_BITS(F)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .operand(operand_bus),
        .result(result_bus)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Exact wide arithmetic; HAM, SCALE round half up and shift; clip each component.
    function automatic quat_result_t quat_compute(operand_t op);
        longint ar, ai, aj, ak, br, bi, bj, bk, s;
        longint raw [4];
        logic signed [W-1:0] clipped [4];
        logic ovf;
        quat_result_t res;
        ar = op.a_real;
        ai = op.a_i;
        aj = op.a_j;
        ak = op.a_k;
        br = op.b_real;
        bi = op.b_i;
        bj = op.b_j;
        bk = op.b_k;
        s  = op.scale;
        ovf = 1'b0;
        case (op.func)
            FUNC_ADD:
            begin
                raw = '{ar + br, ai + bi, aj + bj, ak + bk};
            end
            FUNC_SUB:
            begin
                raw = '{ar - br, ai - bi, aj - bj, ak - bk};
            end
            FUNC_HAM:
            begin
                raw[0] = ar * br - ai * bi - aj * bj - ak * bk;
                raw[1] = ar * bi + ai * br + aj * bk - ak * bj;
                raw[2] = ar * bj - ai * bk + aj * br + ak * bi;
                raw[3] = ar * bk + ai * bj - aj * bi + ak * br;
            end
            default:
            begin
                raw = '{s * br, s * bi, s * bj, s * bk};
            end
        endcase
        for (int c = 0; c < 4; c++)
        begin
            if (op.func == FUNC_HAM || op.func == FUNC_SCALE)
            begin
                raw[c] = (raw[c] + (longint'(1) <<< (F - 1))) >>> F;
            end
            if (raw[c] > longint'(MAXV))
            begin
                clipped[c] = MAXV;
                ovf = 1'b1;
            end
            else if (raw[c] < longint'(MINV))
            begin
                clipped[c] = MINV;
                ovf = 1'b1;
            end
            else
            begin
                clipped[c] = raw[c][W-1:0];
            end
        end
        res = '{clipped[0], clipped[1], clipped[2], clipped[3], ovf};
        return res;
    endfunction

    // Spread 0 is full range, 1 stays within about four units so products
    // mostly avoid clipping, 2 draws edge values, 3 mixes per component.
    function automatic logic signed [W-1:0] pick_component(int unsigned spread);
        int unsigned kind;
        kind = (spread == 3) ? $urandom_range(2) : spread;
        case (kind)
            0: return W'($urandom);
            1: return W'($urandom_range(2047) - 1024);
            default: return EDGE_VALUES[$urandom_range(7)];
        endcase
    endfunction

    function automatic operand_t random_operand();
        operand_t op;
        int unsigned spread;
        spread = $urandom_range(3);
        op.func   = func_t'($urandom_range(3));
        op.a_real = pick_component(spread);
        op.a_i    = pick_component(spread);
        op.a_j    = pick_component(spread);
        op.a_k    = pick_component(spread);
        op.b_real = pick_component(spread);
        op.b_i    = pick_component(spread);
        op.b_j    = pick_component(spread);
        op.b_k    = pick_component(spread);
        op.scale  = pick_component(spread);
        return op;
    endfunction

    task automatic queue_op(input func_t f,
                            input logic signed [W-1:0] ar, ai, aj, ak,
                            input logic signed [W-1:0] br, bi, bj, bk, s);
        operand_t op;
        op = '{f, ar, ai, aj, ak, br, bi, bj, bk, s};
        operand_backlog.push_back(op);
    endtask

    // Driver: a new operand may go out whenever the bus is empty or just moved.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_valid <= 1'b0;
        end
        else
        begin
            if (drive_valid && operand_bus.ready)
            begin
                predicted_results.push_back(quat_compute(drive_op));
            end
            if (!drive_valid || operand_bus.ready)
            begin
                if (operand_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    drive_op    <= operand_backlog.pop_front();
                    drive_valid <= 1'b1;
                end
                else
                begin
                    drive_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: every result transfer is matched against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        quat_result_t got, want;
        if (!rst_n)
        begin
            take_ready <= 1'b0;
        end
        else
        begin
            if (result_bus.valid && take_ready)
            begin
                got = '{result_bus.r_real, result_bus.r_i, result_bus.r_j, result_bus.r_k,
                        result_bus.overflow};
                if (predicted_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result %0d %0d %0d %0d ovf %0b", $time,
                             got.r_real, got.r_i, got.r_j, got.r_k, got.overflow);
                end
                else
                begin
                    want = predicted_results.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        $display("%0t: mismatch expected %0d %0d %0d %0d ovf %0b,",
                                 $time, want.r_real, want.r_i, want.r_j, want.r_k,
                                 want.overflow, " got %0d %0d %0d %0d ovf %0b",
                                 got.r_real, got.r_i, got.r_j, got.r_k, got.overflow);
                    end
                end
            end
            take_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        for (int phase = 0; phase < 4; phase++)
        begin
            @(negedge clk);
            sender_idle_pct    = SENDER_IDLE[phase];
            receiver_stall_pct = RECEIVER_STALL[phase];
            if (phase == 0)
            begin
                queue_op(FUNC_ADD, 0, 0, 0, 0, 0, 0, 0, 0, 0);
                queue_op(FUNC_ADD, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV);
                queue_op(FUNC_ADD, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV);
                queue_op(FUNC_ADD, MAXV, MINV, MAXV, MAXV, -1, MAXV, 0, 1, 0);
                queue_op(FUNC_ADD, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA,
                         16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'sh5555);
                queue_op(FUNC_SUB, 0, 0, MINV, 0, 0, MINV, 1, 0, MINV);
                queue_op(FUNC_SUB, MAXV, MAXV, MAXV, MINV, MAXV, MAXV, MINV, MINV, MAXV);
                queue_op(FUNC_SUB, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555,
                         16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'shAAAA);
                // Unit quaternion times b, then the basis products i*j, j*i and k*k.
                queue_op(FUNC_HAM, ONE, 0, 0, 0, 16'sh0180, 16'shFE00, 16'sh0300, 16'sh0040, MAXV);
                queue_op(FUNC_HAM, 0, ONE, 0, 0, 0, 0, ONE, 0, 0);
                queue_op(FUNC_HAM, 0, 0, ONE, 0, 0, ONE, 0, 0, 0);
                queue_op(FUNC_HAM, 0, 0, 0, ONE, 0, 0, 0, ONE, MINV);
                queue_op(FUNC_HAM, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, 0);
                queue_op(FUNC_HAM, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, 0);
                queue_op(FUNC_HAM, MINV, MAXV, MINV, MAXV, MAXV, MINV, MAXV, MINV, 0);
                // Rounding ties and near-ties in both signs.
                queue_op(FUNC_HAM, 1, 0, 0, 0, HALF, -HALF, 16'sh0081, 16'sh007F, 0);
                queue_op(FUNC_SCALE, MAXV, MINV, MAXV, MINV, 1, -1, 3, -3, HALF);
                queue_op(FUNC_SCALE, 0, 0, 0, 0, MAXV, MAXV, MAXV, MAXV, MAXV);
                queue_op(FUNC_SCALE, 0, 0, 0, 0, MINV, MINV, MINV, MINV, MINV);
                queue_op(FUNC_SCALE, 0, 0, 0, 0, MAXV, MAXV, MINV, MINV, MINV);
                queue_op(FUNC_SCALE, MINV, MINV, MINV, MINV, MAXV, MINV, 0, -1, ONE);
                queue_op(FUNC_SCALE, MAXV, MAXV, MAXV, MAXV, MINV, MAXV, 1, -1, -ONE);
                queue_op(FUNC_SCALE, MAXV, MINV, 1, -1, MAXV, MINV, 16'sh1234, -1, 0);
            end
            repeat (ITEMS_PER_PHASE) operand_backlog.push_back(random_operand());
            // Wait until the backlog is sent and every predicted result has been checked.
            while (operand_backlog.size() != 0 || drive_valid || predicted_results.size() != 0)
            begin
                @(negedge clk);
            end
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatches == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
